FILE: hw/rtl/signed_int_to_decimal_ascii_assert.svh
// assertion macros for the signed integer to decimal text block
// used by the checker module, no other dependencies
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SITDA_ASSERT_NOW(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("sitda check failed");

// condition must hold in the cycle after the trigger
`define SITDA_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("sitda check failed");

`endif

FILE: hw/rtl/sitda_pkg.sv
// shared types, constants and the shift-add-3 step for the decimal text block
// no dependencies
package sitda_pkg;

    localparam int VALUE_W         = 32;
    localparam int CHAR_W          = 8;
    localparam int NUM_DIGITS      = 10;
    localparam int DIGIT_IDX_W     = 4;
    localparam int NUM_STAGES      = 4;
    localparam int STEPS_PER_STAGE = VALUE_W / NUM_STAGES;

    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

    // one item in flight through the conversion stages
    typedef struct packed {
        logic               neg;
        digit_vec_t         bcd;
        logic [VALUE_W-1:0] bin;
    } dabble_t;

    // one double dabble step: adjust digits, then shift one binary bit in
    function automatic dabble_t dabble_step(input dabble_t d);
        dabble_t r;
        r = d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r.bcd[i] >= 4'd5) begin
                r.bcd[i] = r.bcd[i] + 4'd3;
            end
        end
        {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        return r;
    endfunction

endpackage

FILE: hw/rtl/sitda_bcd_stage.sv
// one pipeline stage of the binary to bcd conversion
// depends on sitda_pkg
module sitda_bcd_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sitda_pkg::dabble_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sitda_pkg::dabble_t out_data
);
    import sitda_pkg::*;

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    // stage takes a new item when empty or when its item moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // a fixed group of shift-add-3 steps
    always_comb begin
        data_next = in_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            data_next = dabble_step(data_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hw/rtl/sitda_serializer.sv
// emits sign and digits of one converted number, one character per transaction
// depends on sitda_pkg
module sitda_serializer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sitda_pkg::dabble_t            in_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sitda_pkg::CHAR_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import sitda_pkg::*;

    logic                   busy_reg;
    logic                   neg_pending_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    digit_vec_t             bcd_reg;
    logic                   m_valid_reg;
    logic [CHAR_W-1:0]      m_data_reg;
    logic                   m_last_reg;

    logic                   out_free;
    logic                   emit;
    logic [DIGIT_IDX_W-1:0] top_idx;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign in_ready = !busy_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // most significant nonzero digit, zero prints as one digit
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (in_data.bcd[i] != 4'd0) begin
                top_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            neg_pending_reg <= 1'b0;
            idx_reg         <= '0;
        end else if (!busy_reg) begin
            if (in_valid) begin
                busy_reg        <= 1'b1;
                neg_pending_reg <= in_data.neg;
                idx_reg         <= top_idx;
            end
        end else if (emit) begin
            if (neg_pending_reg) begin
                neg_pending_reg <= 1'b0;
            end else if (idx_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    // digits of the number being sent
    always_ff @(posedge aclk) begin
        if (!busy_reg && in_valid) begin
            bcd_reg <= in_data.bcd;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (neg_pending_reg) begin
                m_data_reg <= MINUS_CHAR;
                m_last_reg <= 1'b0;
            end else begin
                m_data_reg <= ZERO_CHAR + {4'd0, bcd_reg[idx_reg]};
                m_last_reg <= (idx_reg == '0);
            end
        end
    end

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. Each input transaction carries one
// two's complement value; the block returns its text most significant digit first,
// with a leading '-' for negative values, one character per output transaction and
// tlast on the final character. Zero gives "0"; -2147483648 gives "-2147483648".
// A number of n characters (1 to 11) occupies the output sequencer for one load step
// and then one emit step per character, so the sequencer is the bottleneck for back
// to back numbers. From the input register to the first character, the path runs
// through four conversion stages of eight shift-add-3 steps, the sequencer load and
// the output register. The conversion stages keep accepting while the sequencer
// works, until they fill.
// depends on sitda_pkg, sitda_bcd_stage, sitda_serializer
module signed_int_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sitda_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sitda_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] text_char
    output logic                          m_tlast   // last_char
);
    import sitda_pkg::*;

    logic    in_valid_reg;
    dabble_t in_data_reg;
    dabble_t in_data_next;

    logic    st_valid [NUM_STAGES+1];
    logic    st_ready [NUM_STAGES+1];
    dabble_t st_data  [NUM_STAGES+1];

    // sign and magnitude of the incoming value
    always_comb begin
        in_data_next.neg = s_tdata[VALUE_W-1];
        in_data_next.bcd = '0;
        in_data_next.bin = s_tdata[VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    end

    assign s_tready = !in_valid_reg || st_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= in_data_next;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_data[0]  = in_data_reg;

    // conversion pipeline
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        sitda_bcd_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    // character output
    sitda_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_valid[NUM_STAGES]),
        .in_ready (st_ready[NUM_STAGES]),
        .in_data  (st_data[NUM_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/sitda_checker.sv
// port-level checks on the character stream of the decimal text block
// depends on sitda_pkg and signed_int_to_decimal_ascii_assert.svh
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sitda_pkg::CHAR_W-1:0]  m_tdata,
    input logic                          m_tlast
);
    import sitda_pkg::*;

    logic minus_xfer;

    assign minus_xfer = m_tvalid && m_tready && (m_tdata == MINUS_CHAR);

    // a stalled character holds
    `SITDA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // only sign and digit characters appear
    `SITDA_ASSERT_NOW(a_char_set, aclk, aresetn, m_tvalid, (m_tdata == MINUS_CHAR) || ((m_tdata >= ZERO_CHAR) && (m_tdata <= ZERO_CHAR + 8'd9)))

    // the sign never ends a number
    `SITDA_ASSERT_NOW(a_minus_not_last, aclk, aresetn, m_tvalid && (m_tdata == MINUS_CHAR), !m_tlast)

    // a sign is followed at once by a nonzero leading digit
    `SITDA_ASSERT_NEXT(a_minus_then_digit, aclk, aresetn, minus_xfer, m_tvalid && (m_tdata != MINUS_CHAR) && (m_tdata != ZERO_CHAR))

    // first cycle after reset: input ready, no character offered
    `SITDA_ASSERT_NOW(a_idle_after_reset, aclk, aresetn, !$past(aresetn), s_tready && !m_tvalid)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

FILE: tb/sv/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 100ps
// self-checking testbench for signed_int_to_decimal_ascii: directed and random numbers,
// every character checked against typed text or a local decimal text predictor
// depends on sitda_pkg and the signed_int_to_decimal_ascii rtl
module signed_int_to_decimal_ascii_test;

    import sitda_pkg::*;

    localparam int N_DIRECTED     = 20;
    localparam int ITEMS_PER_PASS = 50;
    localparam int N_PASSES       = 4;
    localparam int QUIET_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 24;
    localparam int REPORT_MAX     = 10;

    // one output character as the block should present it
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } text_beat_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [CHAR_W-1:0]   m_tdata;
    logic                m_tlast;

    text_beat_t  pending_chars [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned ready_stall    = 0;
    logic        throttle       = 1'b0;

    // directed numbers; an empty string means the predictor supplies the text
    logic [VALUE_W-1:0] directed_value [N_DIRECTED] = '{
        32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
        32'd123456789, -32'd987654321, 32'd999999999, 32'd1000000000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
        32'hAAAA_AAAA, 32'd1999999999, -32'd1000000000, 32'd7
    };
    string directed_text [N_DIRECTED] = '{
        "0", "1", "-1", "9", "", "", "", "",
        "", "", "", "",
        "2147483647", "-2147483648", "", "",
        "", "", "-1000000000", ""
    };

    signed_int_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 50 MHz clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!throttle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // decimal text of one number, sign first, most significant digit next
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digit_stack [$];
        text_beat_t         beat;
        magnitude = value[VALUE_W-1] ? (32'd0 - value) : value;
        do begin
            digit_stack.push_back(4'(magnitude % 32'd10));
            magnitude = magnitude / 32'd10;
        end while (magnitude != 0);
        if (value[VALUE_W-1]) begin
            beat.text_char = MINUS_CHAR;
            beat.last_char = 1'b0;
            pending_chars.push_back(beat);
        end
        while (digit_stack.size() > 0) begin
            beat.text_char = ZERO_CHAR + CHAR_W'(digit_stack.pop_back());
            beat.last_char = (digit_stack.size() == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    // typed expectation for the rows whose text is plain to see
    function automatic void expect_literal_text(input string text);
        text_beat_t beat;
        for (int i = 0; i < text.len(); i++) begin
            beat.text_char = text[i];
            beat.last_char = (i == text.len() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic void record_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    // random number: some raw bit patterns, some corner values, most spread over digit counts and signs
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned        sel;
        int unsigned        ndig;
        logic [VALUE_W-1:0] scale;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] magnitude;
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
            return $urandom();
        end
        if (sel == 5) begin
            case ($urandom_range(0, 3))
                0: return 32'd0;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        ndig = $urandom_range(1, 10);
        scale = 32'd1;
        repeat (ndig - 1) scale = scale * 32'd10;
        lo = (ndig == 1) ? 32'd0 : scale;
        hi = (ndig == 10) ? 32'h7FFF_FFFF : scale * 32'd10 - 32'd1;
        magnitude = lo + ($urandom() % (hi - lo + 32'd1));
        return $urandom_range(0, 1) ? (32'd0 - magnitude) : magnitude;
    endfunction

    // offer one number, wait for the transaction, then queue its characters
    task automatic send_number(input logic [VALUE_W-1:0] value, input string text);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (text.len() > 0) begin
            expect_literal_text(text);
        end else begin
            predict_decimal_text(value);
        end
    endtask

    // hold the sender until every queued character has come out
    task automatic wait_drained();
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall = ready_stall - 1;
            m_tready <= 1'b0;
        end else begin
            ready_stall = pick_gap();
            m_tready <= (ready_stall == 0);
        end
    end

    // compare each output transaction with the oldest queued character
    always @(posedge aclk) begin
        text_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                record_mismatch($sformatf("unexpected char %h last %b", m_tdata, m_tlast));
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.text_char || m_tlast !== want.last_char) begin
                    record_mismatch($sformatf("char: expected %h last %b, got %h last %b",
                                              want.text_char, want.last_char,
                                              m_tdata, m_tlast));
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, directed numbers, then random passes with and without idling
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_number(directed_value[i], directed_text[i]);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        for (int p = 0; p < N_PASSES; p++) begin
            throttle = (p != 1);
            for (int i = 0; i < ITEMS_PER_PASS; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                    @(posedge aclk);
                end
                send_number(random_value(), "");
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
